// ===== rtl/core/msar_pkg.sv =====
package msar_pkg;

  // field widths
  localparam int CMD_W    = 2;
  localparam int SRC_IN_W = 3;
  localparam int POS_W    = 48;
  localparam int LEN_W    = 16;
  localparam int SMP_W    = 16;
  localparam int ACC_W    = 24;
  localparam int LEAD_W   = 11;

  // source offsets are 49-bit signed, frame distances carried at 52 bits
  localparam int OFS_W = 49;
  localparam int D_W   = 52;

  localparam logic [LEAD_W-1:0] LEAD_RESET = 11'd256;

  // one full turn of the 49-bit offset
  localparam logic [D_W-1:0] OFS_SPAN = 52'h2000000000000;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  // commands
  typedef enum logic [CMD_W-1:0] {
    CMD_MIX_SRC = 2'd0,
    CMD_MIX_ABS = 2'd1,
    CMD_CONSUME = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // operation carried down the pipeline
  typedef enum logic [1:0] {
    OP_IDLE    = 2'd0,
    OP_MIX     = 2'd1,
    OP_CONSUME = 2'd2,
    OP_EMPTY   = 2'd3
  } op_t;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [SRC_IN_W-1:0]     source_index;
    logic [POS_W-1:0]        frame_position;
    logic [LEN_W-1:0]        block_length;
    logic [LEN_W-1:0]        sample_index;
    logic signed [SMP_W-1:0] left_in;
    logic signed [SMP_W-1:0] right_in;
  } in_word_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] left_out;
    logic signed [SMP_W-1:0] right_out;
    logic                    frame_was_filled;
  } out_word_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] left;
    logic signed [ACC_W-1:0] right;
  } acc_pair_t;

endpackage

// ===== rtl/core/multi_source_audio_mix_ring_top.sv =====
// a consume word passes stages 1, 2 and 3 and then the result queue before it shows on out_valid
// throughput: one word per cycle while in_ready is high; one read-modify-write of the ring memory per cycle,
//   with the previous write forwarded, and an 8-entry result queue sized for the pipeline
// reset: synchronous active-low; afterwards a clearing pass zeroes the ring, one entry
//   a cycle through all RING_FRAMES entries, with in_ready low; cfg writes are taken throughout
module multi_source_audio_mix_ring_top #(
  parameter int RING_FRAMES = 2048,
  parameter int MAX_SOURCES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  msar_pkg::in_word_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output msar_pkg::out_word_t            out_data,
  input  logic                           cfg_we,
  input  logic [msar_pkg::LEAD_W-1:0]    cfg_wdata
);
  import msar_pkg::*;

  localparam int IDX_W = $clog2(RING_FRAMES);
  localparam int SRC_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 24'sh7FFFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 24'sh800000;
  localparam logic signed [ACC_W-1:0] Q15_MAX = 24'sd32767;
  localparam logic signed [ACC_W-1:0] Q15_MIN = -24'sd32768;

  // saturating 24-bit add of a Q1.15 sample
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] acc,
                                                       input logic signed [SMP_W-1:0] x);
    logic [ACC_W:0] s;
    s = {acc[ACC_W-1], acc} + {{(ACC_W-SMP_W+1){x[SMP_W-1]}}, x};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  // clamp an accumulator to the Q1.15 range
  function automatic logic signed [SMP_W-1:0] clamp16(input logic signed [ACC_W-1:0] v);
    logic signed [SMP_W-1:0] c;
    if (v > Q15_MAX) begin
      c = 16'sh7FFF;
    end else if (v < Q15_MIN) begin
      c = 16'sh8000;
    end else begin
      c = v[SMP_W-1:0];
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // state registers
  logic [LEAD_W-1:0]   lead_r;
  logic [POS_W-1:0]    rd_pos_r;
  logic [IDX_W-1:0]    rd_idx_r;
  logic [POS_W-1:0]    wr_pos_r;
  logic [OFS_W-1:0]    ofs_r [MAX_SOURCES];
  logic [MAX_SOURCES-1:0] synced_r;
  logic                clearing_r;
  logic [IDX_W-1:0]    clr_idx_r;

  // stage 1: registered input word
  logic                s1_valid_r;
  in_word_t            s1_word_r;
  logic [OFS_W-1:0]    s1_pos_si_r;
  logic [OFS_W-1:0]    s1_pos_len_r;
  logic                s1_len_ok_r;
  logic                s1_src_ok_r;

  // stage 2: decided operation
  op_t                 s2_op_r;
  logic [IDX_W-1:0]    s2_d_r;
  logic [POS_W-1:0]    s2_rd_r;
  logic [IDX_W-1:0]    s2_rd_idx_r;
  logic signed [SMP_W-1:0] s2_l_r;
  logic signed [SMP_W-1:0] s2_r_r;

  // stage 3: memory data back
  op_t                 s3_op_r;
  logic [IDX_W-1:0]    s3_idx_r;
  logic signed [SMP_W-1:0] s3_l_r;
  logic signed [SMP_W-1:0] s3_r_r;
  acc_pair_t           mem_q_r;

  // last write, for forwarding
  logic                fwd_v_r;
  logic [IDX_W-1:0]    fwd_idx_r;
  acc_pair_t           fwd_data_r;

  // result queue
  out_word_t           fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  fifo_wp_r;
  logic [FIFO_AW-1:0]  fifo_rp_r;
  logic [FIFO_AW:0]    fifo_cnt_r;

  // ring memory
  acc_pair_t           mem [RING_FRAMES];

  logic                in_fire;
  logic                fifo_push;
  logic                fifo_pop;
  logic [1:0]          inflight;
  logic [FIFO_AW+1:0]  credit;

  // ---------------------------------------------------------------------------
  // input handshake, credit against the result queue
  always_comb begin
    inflight = 2'((s1_valid_r && s1_word_r.command == CMD_CONSUME) ? 1 : 0)
             + 2'((s2_op_r == OP_CONSUME) ? 1 : 0);
    credit   = {1'b0, fifo_cnt_r} + {{FIFO_AW{1'b0}}, inflight}
             + {{(FIFO_AW+1){1'b0}}, (s3_op_r == OP_CONSUME || s3_op_r == OP_EMPTY)};
    in_ready = !clearing_r && (credit < (FIFO_AW+2)'(FIFO_DEPTH));
    in_fire  = in_valid && in_ready;
  end

  // stage 1 capture with input-only sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
    if (in_fire) begin
      s1_word_r    <= in_data;
      s1_pos_si_r  <= {1'b0, in_data.frame_position} + OFS_W'(in_data.sample_index);
      s1_pos_len_r <= {1'b0, in_data.frame_position} + OFS_W'(in_data.block_length);
      s1_len_ok_r  <= in_data.sample_index < in_data.block_length;
      s1_src_ok_r  <= int'(in_data.source_index) < MAX_SOURCES;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1 decide: offsets, rebase, window check against the read frame
  logic [SRC_W-1:0]  src_sel;
  logic [OFS_W-1:0]  ofs_cur;
  logic              synced_cur;
  logic              is_src;
  logic              is_abs;
  logic              is_cons;
  logic [D_W-1:0]    ofs_ext;
  logic [D_W-1:0]    rd_ext;
  logic [D_W-1:0]    d_si;
  logic [D_W-1:0]    d_len;
  logic [D_W-1:0]    o_raw;
  logic              ofs_wrap;
  logic [D_W-1:0]    d_rb;
  logic              rebase;
  logic [D_W-1:0]    d_sel;
  logic              in_win;
  logic              mix_hit;
  op_t               s2_op_nxt;
  logic [POS_W-1:0]  rd_pos_nxt;
  logic [IDX_W-1:0]  rd_idx_nxt;

  always_comb begin
    src_sel    = SRC_W'(s1_word_r.source_index);
    ofs_cur    = ofs_r[src_sel];
    synced_cur = synced_r[src_sel];
    is_src  = s1_valid_r && s1_word_r.command == CMD_MIX_SRC && s1_src_ok_r && s1_len_ok_r;
    is_abs  = s1_valid_r && s1_word_r.command == CMD_MIX_ABS && s1_len_ok_r;
    is_cons = s1_valid_r && s1_word_r.command == CMD_CONSUME;

    ofs_ext = is_src ? {{(D_W-OFS_W){ofs_cur[OFS_W-1]}}, ofs_cur} : '0;
    rd_ext  = {{(D_W-POS_W){1'b0}}, rd_pos_r};
    d_si    = {{(D_W-OFS_W){1'b0}}, s1_pos_si_r} + ofs_ext - rd_ext;
    d_len   = {{(D_W-OFS_W){1'b0}}, s1_pos_len_r} + ofs_ext - rd_ext;

    // new offset = read + lead - start, kept to 49 bits signed
    o_raw    = rd_ext + {{(D_W-LEAD_W){1'b0}}, lead_r}
             - {{(D_W-POS_W){1'b0}}, s1_word_r.frame_position};
    ofs_wrap = !o_raw[D_W-1] && o_raw[POS_W];
    d_rb     = {{(D_W-LEAD_W){1'b0}}, lead_r} + {{(D_W-LEN_W){1'b0}}, s1_word_r.sample_index}
             - (ofs_wrap ? OFS_SPAN : '0);

    // rebase at block start when unsynced or the block misses the window
    rebase = is_src && (s1_word_r.sample_index == '0) &&
             (!synced_cur || d_len[D_W-1] || (d_len == '0) ||
              (!d_si[D_W-1] && (d_si[D_W-2:0] >= (D_W-1)'(RING_FRAMES))));

    d_sel   = rebase ? d_rb : d_si;
    in_win  = !d_sel[D_W-1] && (d_sel[D_W-2:0] < (D_W-1)'(RING_FRAMES));
    mix_hit = (is_src || is_abs) && in_win;

    if (mix_hit) begin
      s2_op_nxt = OP_MIX;
    end else if (is_cons) begin
      s2_op_nxt = OP_CONSUME;
    end else begin
      s2_op_nxt = OP_IDLE;
    end

    rd_pos_nxt = rd_pos_r + POS_W'(1);
    rd_idx_nxt = (rd_idx_r == IDX_W'(RING_FRAMES - 1)) ? '0 : rd_idx_r + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pos_r <= '0;
      rd_idx_r <= '0;
      synced_r <= '0;
      for (int i = 0; i < MAX_SOURCES; i++) begin
        ofs_r[i] <= '0;
      end
      s2_op_r  <= OP_IDLE;
    end else begin
      s2_op_r <= s2_op_nxt;
      if (is_cons) begin
        rd_pos_r <= rd_pos_nxt;
        rd_idx_r <= rd_idx_nxt;
      end
      if (rebase) begin
        ofs_r[src_sel]    <= o_raw[OFS_W-1:0];
        synced_r[src_sel] <= 1'b1;
      end
    end
    s2_d_r      <= d_sel[IDX_W-1:0];
    s2_rd_r     <= rd_pos_r;
    s2_rd_idx_r <= rd_idx_r;
    s2_l_r      <= s1_word_r.left_in;
    s2_r_r      <= s1_word_r.right_in;
  end

  // ---------------------------------------------------------------------------
  // stage 2: ring address, write frame, fill check, memory read
  logic [IDX_W:0]    idx_sum;
  logic [IDX_W-1:0]  rd_addr;
  logic [POS_W-1:0]  frame_end;
  logic              filled;
  op_t               s3_op_nxt;

  always_comb begin
    idx_sum = {1'b0, s2_rd_idx_r} + {1'b0, s2_d_r};
    if (idx_sum >= (IDX_W+1)'(RING_FRAMES)) begin
      idx_sum = idx_sum - (IDX_W+1)'(RING_FRAMES);
    end
    rd_addr   = (s2_op_r == OP_MIX) ? idx_sum[IDX_W-1:0] : s2_rd_idx_r;
    frame_end = s2_rd_r + POS_W'(s2_d_r) + POS_W'(1);
    filled    = wr_pos_r > s2_rd_r;
    unique case (s2_op_r)
      OP_MIX:     s3_op_nxt = OP_MIX;
      OP_CONSUME: s3_op_nxt = filled ? OP_CONSUME : OP_EMPTY;
      default:    s3_op_nxt = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r <= '0;
      s3_op_r  <= OP_IDLE;
    end else begin
      s3_op_r <= s3_op_nxt;
      if (s2_op_r == OP_MIX && frame_end > wr_pos_r) begin
        wr_pos_r <= frame_end;
      end
    end
    s3_idx_r <= rd_addr;
    s3_l_r   <= s2_l_r;
    s3_r_r   <= s2_r_r;
  end

  // ---------------------------------------------------------------------------
  // stage 3: modify and write back, with the previous write forwarded
  acc_pair_t         cur;
  acc_pair_t         mixed;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  acc_pair_t         mem_wdata;
  out_word_t         res;

  always_comb begin
    cur = (fwd_v_r && fwd_idx_r == s3_idx_r) ? fwd_data_r : mem_q_r;
    mixed.left  = sat_add(cur.left, s3_l_r);
    mixed.right = sat_add(cur.right, s3_r_r);

    if (clearing_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = '0;
    end else begin
      mem_we    = (s3_op_r == OP_MIX) || (s3_op_r == OP_CONSUME);
      mem_waddr = s3_idx_r;
      mem_wdata = (s3_op_r == OP_MIX) ? mixed : '0;
    end

    if (s3_op_r == OP_CONSUME) begin
      res.left_out         = clamp16(cur.left);
      res.right_out        = clamp16(cur.right);
      res.frame_was_filled = 1'b1;
    end else begin
      res = '0;
    end
  end

  // ring memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else begin
      fwd_v_r <= mem_we;
    end
    fwd_idx_r  <= mem_waddr;
    fwd_data_r <= mem_wdata;
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + IDX_W'(1);
      if (clr_idx_r == IDX_W'(RING_FRAMES - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // rebase lead register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= LEAD_RESET;
    end else if (cfg_we) begin
      lead_r <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // result queue
  always_comb begin
    fifo_push = (s3_op_r == OP_CONSUME) || (s3_op_r == OP_EMPTY);
    out_valid = fifo_cnt_r != '0;
    out_data  = fifo_r[fifo_rp_r];
    fifo_pop  = out_valid && out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fifo_wp_r  <= '0;
      fifo_rp_r  <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (fifo_push) begin
        fifo_wp_r <= fifo_wp_r + FIFO_AW'(1);
      end
      if (fifo_pop) begin
        fifo_rp_r <= fifo_rp_r + FIFO_AW'(1);
      end
      if (fifo_push && !fifo_pop) begin
        fifo_cnt_r <= fifo_cnt_r + (FIFO_AW+1)'(1);
      end else if (fifo_pop && !fifo_push) begin
        fifo_cnt_r <= fifo_cnt_r - (FIFO_AW+1)'(1);
      end
    end
    if (fifo_push) begin
      fifo_r[fifo_wp_r] <= res;
    end
  end

  // ---------------------------------------------------------------------------
  // checks

  // queued plus in-flight consume words never exceed the queue
  assert property (@(posedge clk) disable iff (!rst_n)
    credit <= (FIFO_AW+2)'(FIFO_DEPTH))
    else $error("result queue credit overrun");

  // no word moves through the pipeline during the clearing pass
  assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> (!s1_valid_r && s2_op_r == OP_IDLE && s3_op_r == OP_IDLE))
    else $error("pipeline active during clearing pass");

  // ring writes stay inside the ring
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (int'(mem_waddr) < RING_FRAMES))
    else $error("ring write address out of range");

  // a consume of an unfilled frame leaves the memory alone
  assert property (@(posedge clk) disable iff (!rst_n)
    (s3_op_r == OP_EMPTY) |-> !mem_we)
    else $error("write on empty consume");

endmodule

// ===== dv/msar_ring_checker.sv =====
`timescale 1ns / 100ps

module msar_ring_checker #(
  parameter int RING_FRAMES = 2048,
  parameter int MAX_SOURCES = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  msar_pkg::in_word_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  msar_pkg::out_word_t         out_data,
  input  logic                        cfg_we,
  input  logic [msar_pkg::LEAD_W-1:0] cfg_wdata,
  output int                          n_fail,
  output int                          n_pending
);
  import msar_pkg::*;

  localparam longint ACC_HI = (longint'(1) << (ACC_W - 1)) - 1;
  localparam longint ACC_LO = -(longint'(1) << (ACC_W - 1));

  // predicted ring contents and positions
  logic signed [ACC_W-1:0] ring_left  [RING_FRAMES];
  logic signed [ACC_W-1:0] ring_right [RING_FRAMES];
  logic [POS_W-1:0]        read_frame;
  logic [POS_W-1:0]        write_frame;
  logic signed [OFS_W-1:0] src_offset [MAX_SOURCES];
  logic                    src_locked [MAX_SOURCES];
  logic [LEAD_W-1:0]       lead_frames;

  // frames owed to the consumer, oldest first
  out_word_t frames_due [$];
  out_word_t oldest_due;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W-1:0] acc,
                                                      input logic signed [SMP_W-1:0] x);
    longint s;
    s = longint'(acc);
    s = s + longint'(x);
    if (s > ACC_HI) s = ACC_HI;
    if (s < ACC_LO) s = ACC_LO;
    return s[ACC_W-1:0];
  endfunction

  // clamp to +/-1.0 in q1.15
  function automatic logic signed [SMP_W-1:0] to_q15(input logic signed [ACC_W-1:0] acc);
    if (acc > 32767) return 16'sh7FFF;
    if (acc < -32768) return 16'sh8000;
    return acc[SMP_W-1:0];
  endfunction

  // add one pair into a ring frame if it lies inside the read window
  task automatic mix_frame(input longint f, input logic signed [SMP_W-1:0] l,
                           input logic signed [SMP_W-1:0] r);
    longint rd;
    longint fe;
    int slot;
    logic [POS_W-1:0] next_end;
    rd = longint'(read_frame);
    if (f < rd || f >= rd + RING_FRAMES) return;
    slot = int'(f % RING_FRAMES);
    ring_left[slot]  = sat_acc(ring_left[slot], l);
    ring_right[slot] = sat_acc(ring_right[slot], r);
    fe = f + 1;
    next_end = fe[POS_W-1:0];
    if (next_end > write_frame) write_frame = next_end;
  endtask

  // apply one accepted input word to the predicted ring
  task automatic ring_apply(input in_word_t w);
    longint rd;
    longint pos;
    longint len;
    longint si;
    longint ofs;
    longint eff;
    logic [63:0] wrapped;
    int s;
    int slot;
    out_word_t due;
    rd  = longint'(read_frame);
    pos = longint'(w.frame_position);
    len = longint'(w.block_length);
    si  = longint'(w.sample_index);
    s   = int'(w.source_index);
    case (cmd_t'(w.command))
      CMD_MIX_SRC: begin
        if (s < MAX_SOURCES && si < len) begin
          ofs = longint'(src_offset[s]);
          eff = pos + ofs;
          // resync at block start when unsynced or the block misses the window
          if (si == 0 && (!src_locked[s] || eff + len <= rd || eff >= rd + RING_FRAMES)) begin
            wrapped = rd + longint'(lead_frames) - pos;
            src_offset[s] = wrapped[OFS_W-1:0];
            src_locked[s] = 1'b1;
            ofs = longint'(src_offset[s]);
            eff = pos + ofs;
          end
          mix_frame(eff + si, w.left_in, w.right_in);
        end
      end
      CMD_MIX_ABS: begin
        if (si < len) mix_frame(pos + si, w.left_in, w.right_in);
      end
      CMD_CONSUME: begin
        slot = int'(read_frame % RING_FRAMES);
        due.frame_was_filled = (write_frame > read_frame);
        if (due.frame_was_filled) begin
          due.left_out  = to_q15(ring_left[slot]);
          due.right_out = to_q15(ring_right[slot]);
          ring_left[slot]  = '0;
          ring_right[slot] = '0;
        end else begin
          due.left_out  = '0;
          due.right_out = '0;
        end
        frames_due.push_back(due);
        read_frame = read_frame + 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic match_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RING_FRAMES; i++) begin
        ring_left[i]  = '0;
        ring_right[i] = '0;
      end
      for (int i = 0; i < MAX_SOURCES; i++) begin
        src_offset[i] = '0;
        src_locked[i] = 1'b0;
      end
      read_frame  = '0;
      write_frame = '0;
      lead_frames = LEAD_RESET;
      frames_due.delete();
      n_fail = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          $error("output word with no frame pending: left_out %0d right_out %0d",
                 out_data.left_out, out_data.right_out);
          n_fail++;
        end else begin
          oldest_due = frames_due.pop_front();
          match_field("left_out", oldest_due.left_out, out_data.left_out);
          match_field("right_out", oldest_due.right_out, out_data.right_out);
          match_field("frame_was_filled", oldest_due.frame_was_filled,
                      out_data.frame_was_filled);
        end
      end
      if (cfg_we) lead_frames = cfg_wdata;
      if (in_valid && in_ready) ring_apply(in_data);
    end
    n_pending = frames_due.size();
  end

endmodule

// ===== dv/tb_multi_source_audio_mix_ring_top.sv =====
`timescale 1ns / 100ps

module tb_multi_source_audio_mix_ring_top;
  import msar_pkg::*;

  localparam int RING        = 2048;
  localparam int SOURCES     = 8;
  localparam int PHASES      = 5;
  localparam int LIVE_TARGET = 1600;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = 8;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_word_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_word_t         out_data;
  logic              cfg_we;
  logic [LEAD_W-1:0] cfg_wdata;
  int                n_fail;
  int                n_pending;

  // stimulus bookkeeping: read position as the block will see it, per-source time
  longint frames_read;
  longint src_clock [SOURCES];
  int     live_items;
  int     send_idle_pct = 25;
  int     recv_idle_pct = 25;
  bit     hold_rx = 1'b0;
  bit     hold_done = 1'b0;

  always #2 clk = ~clk;

  multi_source_audio_mix_ring_top #(
    .RING_FRAMES(RING),
    .MAX_SOURCES(SOURCES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  msar_ring_checker #(
    .RING_FRAMES(RING),
    .MAX_SOURCES(SOURCES)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .n_fail    (n_fail),
    .n_pending (n_pending)
  );

  // run limit
  initial begin
    #400_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [SMP_W-1:0] pick_sample();
    int k;
    logic [31:0] v;
    k = $urandom_range(9);
    v = $urandom;
    if (k == 0) return 16'h7FFF;
    if (k == 1) return 16'h8000;
    return v[SMP_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[POS_W-1:0];
  endfunction

  function automatic in_word_t make_word(input cmd_t c, input int s, input logic [POS_W-1:0] p,
                                         input int len, input int si,
                                         input logic [SMP_W-1:0] l, input logic [SMP_W-1:0] r);
    in_word_t w;
    w.command        = c;
    w.source_index   = s[SRC_IN_W-1:0];
    w.frame_position = p;
    w.block_length   = len[LEN_W-1:0];
    w.sample_index   = si[LEN_W-1:0];
    w.left_in        = l;
    w.right_in       = r;
    return w;
  endfunction

  // offer one word, with random idle cycles ahead of it
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (w.command == CMD_CONSUME) begin
      frames_read++;
      live_items++;
    end else if (w.command != CMD_NONE && w.sample_index < w.block_length) begin
      live_items++;
    end
  endtask

  task automatic send_mix(input cmd_t c, input int s, input logic [POS_W-1:0] p,
                          input int len, input int si);
    send_word(make_word(c, s, p, len, si, pick_sample(), pick_sample()));
  endtask

  task automatic consume_run(input int n);
    repeat (n) begin
      send_word(make_word(CMD_CONSUME, $urandom_range(7), rand_pos(), $urandom, $urandom,
                          16'($urandom), 16'($urandom)));
    end
  endtask

  // one well-formed block from a source, mostly contiguous in source time
  task automatic source_block();
    int s;
    int len;
    int k;
    longint start;
    logic [POS_W-1:0] p;
    s   = $urandom_range(SOURCES - 1);
    len = ($urandom_range(19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    k   = $urandom_range(99);
    if (k < 80) start = src_clock[s];
    else if (k < 90) start = src_clock[s] + $urandom_range(2100, 5000);
    else if (k < 95) start = src_clock[s] - longint'($urandom_range(1, 64));
    else start = longint'(rand_pos());
    p = start[POS_W-1:0];
    src_clock[s] = longint'(p) + len;
    for (int si = 0; si < len; si++) begin
      if ($urandom_range(9) == 0) consume_run($urandom_range(1, 4));
      send_mix(CMD_MIX_SRC, s, p, len, si);
    end
  endtask

  // block at an absolute frame near the read window
  task automatic absolute_block();
    longint base;
    int len;
    if ($urandom_range(4) != 0) base = frames_read - 16 + longint'($urandom_range(400));
    else base = frames_read + longint'($urandom_range(2040, 2050));
    len = $urandom_range(1, 8);
    for (int si = 0; si < len; si++) begin
      send_mix(CMD_MIX_ABS, $urandom_range(7), base[POS_W-1:0], len, si);
    end
  endtask

  // malformed words: index past block length, unused command, block without its start
  task automatic broken_word();
    int len;
    int si;
    int s;
    case ($urandom_range(3))
      0: begin
        len = $urandom_range(40);
        si  = len + $urandom_range(200);
        send_mix(($urandom_range(1) == 0) ? CMD_MIX_SRC : CMD_MIX_ABS, $urandom_range(7),
                 frames_read[POS_W-1:0], len, si);
      end
      1: send_mix(CMD_MIX_ABS, $urandom_range(7), rand_pos(), 65535, 65535);
      2: send_word(make_word(CMD_NONE, $urandom_range(7), rand_pos(), $urandom, $urandom,
                             16'($urandom), 16'($urandom)));
      default: begin
        s   = $urandom_range(SOURCES - 1);
        si  = $urandom_range(1, 8);
        len = si + $urandom_range(1, 4);
        send_mix(CMD_MIX_SRC, s, src_clock[s][POS_W-1:0], len, si);
      end
    endcase
  endtask

  // stop offering, let every frame come back, then let the pipe drain
  task automatic settle();
    in_valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  // result side: random stalls, one long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rx && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // stimulus
  initial begin
    int lead_val;
    int phase_end;
    int k;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    frames_read = 0;
    live_items  = 0;
    foreach (src_clock[i]) src_clock[i] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty frame, clamping, window edges, field extremes, ignored words
    consume_run(1);
    repeat (2) begin
      send_word(make_word(CMD_MIX_ABS, 0, frames_read[POS_W-1:0], 1, 0, 16'h7FFF, 16'h8000));
    end
    send_word(make_word(CMD_MIX_ABS, 1, POS_W'(frames_read + 2047), 2, 0, 16'h0001, 16'hFFFF));
    send_word(make_word(CMD_MIX_ABS, 1, POS_W'(frames_read + 2047), 2, 1, 16'h0001, 16'hFFFF));
    send_word(make_word(CMD_MIX_ABS, 2, '1, 65535, 65534, 16'h7FFF, 16'h7FFF));
    send_word(make_word(CMD_MIX_ABS, 0, frames_read[POS_W-1:0], 0, 0, 16'h1234, 16'h4321));
    send_word(make_word(CMD_MIX_ABS, 0, frames_read[POS_W-1:0], 65535, 65535, 16'h1234,
                        16'h4321));
    send_word(make_word(CMD_NONE, 7, rand_pos(), $urandom, $urandom, 16'($urandom),
                        16'($urandom)));
    send_word(make_word(CMD_MIX_SRC, 0, '0, 5, 5, 16'h1111, 16'h2222));
    for (int si = 0; si < 3; si++) begin
      send_word(make_word(CMD_MIX_SRC, 0, '0, 3, si, 16'hFFFF, 16'h0001));
    end
    send_word(make_word(CMD_MIX_SRC, 7, '1, 65535, 0, 16'h8000, 16'h7FFF));
    // huge offset on source 7 puts this frame below zero
    send_word(make_word(CMD_MIX_SRC, 7, '0, 4, 1, 16'h4000, 16'hC000));
    send_word(make_word(CMD_MIX_SRC, 3, POS_W'(frames_read + 3), 4, 2, 16'h0100, 16'hFF00));
    consume_run(4);

    // random phases, each under its own lead setting
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: lead_val = 0;
        1: lead_val = (1 << LEAD_W) - 1;
        2: lead_val = $urandom_range(1, (1 << LEAD_W) - 2);
        3: lead_val = $urandom_range(1, 16);
        default: lead_val = int'(LEAD_RESET);
      endcase
      cfg_we    <= 1'b1;
      cfg_wdata <= lead_val[LEAD_W-1:0];
      @(negedge clk);
      cfg_we <= 1'b0;
      send_idle_pct = (ph == 3) ? 0 : 25;
      recv_idle_pct = (ph == 3) ? 0 : 25;

      // pile onto one frame until both channels saturate, then read it out
      if (ph == 0) begin
        k = int'(frames_read) + int'($urandom_range(2, 6));
        repeat (260) begin
          send_word(make_word(CMD_MIX_ABS, 0, POS_W'(k), 1, 0, 16'h7FFF, 16'h8000));
        end
        consume_run(12);
      end
      // consumer holds off while consumes keep coming
      if (ph == 2) begin
        hold_rx = 1'b1;
        consume_run(40);
      end

      phase_end = (LIVE_TARGET * (ph + 1)) / PHASES;
      while (live_items < phase_end) begin
        k = $urandom_range(99);
        if (k < 33) consume_run($urandom_range(1, 16));
        else if (k < 63) source_block();
        else if (k < 78) absolute_block();
        else if (k < 88) begin
          send_word(make_word(cmd_t'($urandom_range(3)), $urandom_range(7), rand_pos(),
                              $urandom, $urandom, 16'($urandom), 16'($urandom)));
        end else broken_word();
      end
    end

    settle();
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== multi_source_audio_mix_ring_top.f =====
rtl/core/msar_pkg.sv
rtl/core/multi_source_audio_mix_ring_top.sv
dv/msar_ring_checker.sv
dv/tb_multi_source_audio_mix_ring_top.sv
